FILE: src/bfsp_pkg.sv
package bfsp_pkg;

  localparam int unsigned VIDX_W       = 4;
  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned WADDR_W      = 2 * VIDX_W;
  localparam int unsigned VCNT_W       = 5;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  typedef logic [VIDX_W-1:0] vidx_t;

  // Register index, taken from paddr[2].
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_START_VERTEX = 1'b1;

  localparam logic [VCNT_W-1:0] VERTEX_COUNT_RST = VCNT_W'(MAX_VERTICES);
  localparam vidx_t             START_VERTEX_RST = '0;

endpackage

FILE: src/bfsp_if.sv
interface bfsp_in_if #(
  parameter int unsigned WEIGHT_BITS = 16
);
  import bfsp_pkg::*;

  logic                   valid;
  logic                   ready;
  vidx_t                  row;
  vidx_t                  col;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   last;

  modport source (output valid, row, col, weight, last, input ready);
  modport sink (input valid, row, col, weight, last, output ready);
endinterface

interface bfsp_out_if #(
  parameter int unsigned DIST_BITS = 24
);
  import bfsp_pkg::*;

  logic                 valid;
  logic                 ready;
  vidx_t                vertex;
  logic [DIST_BITS-1:0] distance;
  vidx_t                predecessor;
  logic                 has_predecessor;
  logic                 cycle_flag;
  logic                 last_result;

  modport source (output valid, vertex, distance, predecessor, has_predecessor, cycle_flag,
                  last_result, input ready);
  modport sink (input valid, vertex, distance, predecessor, has_predecessor, cycle_flag,
                last_result, output ready);
endinterface

FILE: src/bellman_ford_shortest_paths.sv
// Single-source shortest paths by Bellman-Ford over a dense graph of up to 16
// vertices. Adjacency entries are taken one per cycle and written into a weight
// memory; the entry marked last starts the search from start_vertex. The search
// runs vertex_count-1 relaxation rounds and one check round, each visiting every
// edge in row then column order, then emits one result per vertex. Every
// edge passes through S_EDGE_RD (read weight and destination distance) and
// S_EDGE_WR (compare and write back), and every row through S_ROW to fetch the
// source distance, all through the single read port of the distance memory.
// No input is taken while a search runs.
module bellman_ford_shortest_paths #(
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned DIST_BITS   = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bfsp_in_if.sink                        in_i,
  bfsp_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfsp_pkg::PADDR_W-1:0]   paddr,
  input  logic [bfsp_pkg::PDATA_W-1:0]   pwdata,
  output logic [bfsp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import bfsp_pkg::*;

  localparam int unsigned SUM_W = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam logic [DIST_BITS-1:0] DMAX = '1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT,
    S_ROW,
    S_EDGE_RD,
    S_EDGE_WR,
    S_OUT,
    S_OUT_LD
  } state_e;

  // Configuration registers.
  logic [VCNT_W-1:0] vertex_count_q;
  vidx_t             start_vertex_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VERTEX_COUNT_RST;
      start_vertex_q <= START_VERTEX_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_VERTEX_COUNT: vertex_count_q <= pwdata[VCNT_W-1:0];
        REG_START_VERTEX: start_vertex_q <= pwdata[VIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VERTEX_COUNT: prdata = PDATA_W'(vertex_count_q);
      REG_START_VERTEX: prdata = PDATA_W'(start_vertex_q);
      default:          prdata = '0;
    endcase
  end

  // Control state.
  state_e               state_q;
  vidx_t                lim_q;
  vidx_t                rnd_q;
  vidx_t                r_q;
  vidx_t                p_q;
  vidx_t                v_q;
  logic                 improve_q;
  logic [DIST_BITS-1:0] dist_r_q;
  logic                 out_valid_q;
  vidx_t                out_vertex_q;
  logic [DIST_BITS-1:0] out_dist_q;
  vidx_t                out_pred_q;
  logic                 out_has_pred_q;
  logic                 out_cycle_q;
  logic                 out_last_q;

  logic                 in_xfer;
  logic                 out_xfer;
  vidx_t                lim_d;
  logic                 check_rnd;
  logic                 start_in;

  // Memories and their read registers.
  logic [WEIGHT_BITS-1:0] w_mem [MAX_VERTICES*MAX_VERTICES];
  logic [DIST_BITS-1:0]   dist_mem [MAX_VERTICES];
  vidx_t                  pred_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] dvld_q;
  logic [MAX_VERTICES-1:0] pvld_q;
  logic [WEIGHT_BITS-1:0] w_rd_q;
  logic [DIST_BITS-1:0]   dist_rd_q;
  vidx_t                  pred_rd_q;
  logic                   dvld_rd_q;
  logic                   pvld_rd_q;

  vidx_t                  dist_ra;
  vidx_t                  dist_wa;
  logic [DIST_BITS-1:0]   dist_wd;
  logic                   dist_we;
  logic                   pred_we;

  logic [DIST_BITS-1:0]   dist_p;
  logic [DIST_BITS-1:0]   dist_rd_eff;
  logic [SUM_W-1:0]       sum;
  logic [DIST_BITS-1:0]   cand;
  logic                   skip;
  logic                   better;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign out_xfer  = out_o.valid && out_o.ready;
  assign in_i.ready = (state_q == S_LOAD);
  assign check_rnd = (rnd_q == lim_q);
  assign start_in  = (start_vertex_q <= lim_q);

  // Vertex count zero acts as one, counts above the store act as the full store.
  always_comb begin
    if (vertex_count_q == '0) begin
      lim_d = '0;
    end else if (vertex_count_q > VCNT_W'(MAX_VERTICES)) begin
      lim_d = VIDX_W'(MAX_VERTICES - 1);
    end else begin
      lim_d = VIDX_W'(vertex_count_q - VCNT_W'(1));
    end
  end

  // Edge evaluation on the registered read data.
  assign dist_rd_eff = dvld_rd_q ? dist_rd_q : DMAX;
  assign dist_p      = dist_rd_eff;
  assign sum         = SUM_W'(dist_r_q) + SUM_W'(w_rd_q);
  assign cand        = (sum > SUM_W'(DMAX)) ? DMAX : sum[DIST_BITS-1:0];
  assign skip        = (w_rd_q == '0) || (r_q == p_q) || (dist_r_q == DMAX);
  assign better      = !skip && (cand < dist_p);

  always_comb begin
    case (state_q)
      S_ROW:     dist_ra = r_q;
      S_EDGE_RD: dist_ra = p_q;
      default:   dist_ra = v_q;
    endcase
  end

  assign pred_we = (state_q == S_EDGE_WR) && better && !check_rnd;
  assign dist_we = pred_we || ((state_q == S_INIT) && start_in);
  assign dist_wa = (state_q == S_INIT) ? start_vertex_q : p_q;
  assign dist_wd = (state_q == S_INIT) ? '0 : cand;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      w_mem[{in_i.row, in_i.col}] <= in_i.weight;
    end
    w_rd_q <= w_mem[{r_q, p_q}];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    dist_rd_q <= dist_mem[dist_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pred_we) begin
      pred_mem[p_q] <= r_q;
    end
    pred_rd_q <= pred_mem[dist_ra];
  end

  // Valid bits: an entry not written in this search reads as unreached.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q    <= '0;
      pvld_q    <= '0;
      dvld_rd_q <= 1'b0;
      pvld_rd_q <= 1'b0;
    end else begin
      dvld_rd_q <= dvld_q[dist_ra];
      pvld_rd_q <= pvld_q[dist_ra];
      if (state_q == S_INIT) begin
        dvld_q <= start_in ? (MAX_VERTICES'(1) << start_vertex_q) : '0;
        pvld_q <= '0;
      end else if (pred_we) begin
        dvld_q[p_q] <= 1'b1;
        pvld_q[p_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_LOAD;
      lim_q          <= '0;
      rnd_q          <= '0;
      r_q            <= '0;
      p_q            <= '0;
      v_q            <= '0;
      improve_q      <= 1'b0;
      dist_r_q       <= '0;
      out_valid_q    <= 1'b0;
      out_vertex_q   <= '0;
      out_dist_q     <= '0;
      out_pred_q     <= '0;
      out_has_pred_q <= 1'b0;
      out_cycle_q    <= 1'b0;
      out_last_q     <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_xfer && in_i.last) begin
            lim_q   <= lim_d;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          improve_q <= 1'b0;
          rnd_q     <= '0;
          r_q       <= '0;
          p_q       <= '0;
          state_q   <= S_ROW;
        end
        S_ROW: begin
          state_q <= S_EDGE_RD;
        end
        S_EDGE_RD: begin
          // The source distance cannot change within its row: self-loops are skipped.
          if (p_q == '0) begin
            dist_r_q <= dist_rd_eff;
          end
          state_q <= S_EDGE_WR;
        end
        S_EDGE_WR: begin
          if (better && check_rnd) begin
            improve_q <= 1'b1;
          end
          if (p_q == lim_q) begin
            p_q <= '0;
            if (r_q == lim_q) begin
              r_q <= '0;
              if (check_rnd) begin
                v_q     <= '0;
                state_q <= S_OUT;
              end else begin
                rnd_q   <= rnd_q + VIDX_W'(1);
                state_q <= S_ROW;
              end
            end else begin
              r_q     <= r_q + VIDX_W'(1);
              state_q <= S_ROW;
            end
          end else begin
            p_q     <= p_q + VIDX_W'(1);
            state_q <= S_EDGE_RD;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= S_OUT_LD;
          end
        end
        S_OUT_LD: begin
          out_valid_q    <= 1'b1;
          out_vertex_q   <= v_q;
          out_dist_q     <= dist_rd_eff;
          out_pred_q     <= pvld_rd_q ? pred_rd_q : '0;
          out_has_pred_q <= pvld_rd_q;
          out_cycle_q    <= improve_q;
          out_last_q     <= (v_q == lim_q);
          if (v_q == lim_q) begin
            state_q <= S_LOAD;
          end else begin
            v_q     <= v_q + VIDX_W'(1);
            state_q <= S_OUT;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.vertex          = out_vertex_q;
  assign out_o.distance        = out_dist_q;
  assign out_o.predecessor     = out_pred_q;
  assign out_o.has_predecessor = out_has_pred_q;
  assign out_o.cycle_flag      = out_cycle_q;
  assign out_o.last_result     = out_last_q;

  // The check round only observes; it never writes the distance memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDGE_WR && check_rnd) |-> !dist_we)
    else $error("distance written during the check round");

  // A result is only loaded into an empty output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_LD) |-> !out_valid_q)
    else $error("pending result overwritten");

  // After the final result of a search is transferred, no result follows at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_last_q) |=> !out_valid_q)
    else $error("result after the final vertex");

  // No input is taken while a search runs or its results are being loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (state_q == S_LOAD))
    else $error("input transfer during search");

endmodule
